// ===== rtl/core/dir_offset_subvol_transform_top_assert.svh =====
// Assertion macros shared by the directory offset transform RTL.
`ifndef DIR_OFFSET_SUBVOL_TRANSFORM_TOP_ASSERT_SVH
`define DIR_OFFSET_SUBVOL_TRANSFORM_TOP_ASSERT_SVH

// Implication checked on every rising clock edge, off while reset is held.
`define DOST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define DOST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dost_pkg.sv =====
// ----------------------------------------------------------------------------
// dost_pkg
// Types, constants and helpers of the directory offset transform pipeline.
// ----------------------------------------------------------------------------
package dost_pkg;

  localparam int unsigned MAX_SUBVOLS = 64;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned OFF_W       = 64;
  localparam int unsigned DIV_STEPS   = 8;
  localparam int unsigned DIV_STAGES  = OFF_W / DIV_STEPS;

  localparam logic [OFF_W-1:0] ALL_ONES       = '1;
  localparam logic [OFF_W-1:0] OFF_LOW63_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OFF_W-1:0] TOP_BIT        = 64'h4000_0000_0000_0000;

  // item state carried down the pipeline
  typedef struct packed {
    logic             dec_div;  // decode by division, result comes from q/rem
    logic [OFF_W-1:0] q;        // dividend shifting into quotient
    logic [CNT_W-1:0] rem;      // partial remainder
    logic [CNT_W-1:0] cnt;      // effective member count
    logic [OFF_W-1:0] res;      // result offset for the non-divide paths
    logic [IDX_W-1:0] sub;      // member index for the non-divide paths
    logic             err;      // index out of range
  } dost_item_t;

  // ceiling of log2 for a count of 1..64
  function automatic logic [2:0] ceil_log2(input logic [CNT_W-1:0] n);
    logic [2:0]       b;
    logic [CNT_W-1:0] m;
    b = '0;
    m = n - 7'd1;
    for (int i = 0; i < CNT_W; i++) begin
      if ((m >> i) != '0) begin
        b = 3'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/dost_front.sv =====
// ----------------------------------------------------------------------------
// dost_front
// First stage: clamps the count, takes the encode and huge decode paths and
// sets up the long division for small-offset decode.
// ----------------------------------------------------------------------------
module dost_front import dost_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic             action_i,
  input  logic [OFF_W-1:0] off_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dost_item_t       item_o
);

  logic             valid_q;
  dost_item_t       item_q, item_d;
  logic [CNT_W-1:0] cnt;
  logic [2:0]       b;
  logic [OFF_W-1:0] low_mask, hi_mask, prod;
  logic [IDX_W-1:0] hsub;

  // effective count and masks
  always_comb begin
    if (count_i == '0) begin
      cnt = 7'd1;
    end else if (count_i > CNT_W'(MAX_SUBVOLS)) begin
      cnt = CNT_W'(MAX_SUBVOLS);
    end else begin
      cnt = count_i;
    end
    b        = ceil_log2(cnt);
    low_mask = ALL_ONES << b;
    hi_mask  = ~(OFF_LOW63_MASK >> (32'(b) + 32'd1));
    prod     = off_i * OFF_W'(cnt);
    hsub     = off_i[IDX_W-1:0] & ~low_mask[IDX_W-1:0];
  end

  // result for every path but the division
  always_comb begin
    item_d         = '0;
    item_d.cnt     = cnt;
    item_d.q       = off_i;
    item_d.rem     = '0;
    if (!action_i) begin
      item_d.err = ({1'b0, idx_i} >= cnt);
      if (item_d.err) begin
        item_d.res = ALL_ONES;
      end else if (off_i == ALL_ONES || cnt == 7'd1) begin
        item_d.res = off_i;
      end else if ((off_i & hi_mask) != '0) begin
        item_d.res = TOP_BIT | ((off_i >> 1) & low_mask) | OFF_W'(idx_i);
      end else begin
        item_d.res = prod + OFF_W'(idx_i);
      end
    end else if (cnt == 7'd1) begin
      item_d.res = off_i;
    end else if ((off_i & TOP_BIT) != '0) begin
      item_d.res = ((off_i & ~TOP_BIT) & low_mask) << 1;
      if ({1'b0, hsub} >= cnt) begin
        item_d.err = 1'b1;
      end else begin
        item_d.sub = hsub;
      end
    end else begin
      item_d.dec_div = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/dost_div_stage.sv =====
// ----------------------------------------------------------------------------
// dost_div_stage
// One stage of the restoring long division: eight quotient bits per stage.
// ----------------------------------------------------------------------------
module dost_div_stage import dost_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  dost_item_t item_i,
  output logic       valid_o,
  input  logic       ready_i,
  output dost_item_t item_o
);

  logic       valid_q;
  dost_item_t item_q, item_d;
  logic [CNT_W:0] r;

  // shift-subtract steps, remainder stays below count
  always_comb begin
    item_d = item_i;
    r      = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r        = {item_d.rem, item_d.q[OFF_W-1]};
      item_d.q = {item_d.q[OFF_W-2:0], 1'b0};
      if (r >= {1'b0, item_d.cnt}) begin
        r           = r - {1'b0, item_d.cnt};
        item_d.q[0] = 1'b1;
      end
      item_d.rem = r[CNT_W-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/dir_offset_subvol_transform_top.sv =====
// ----------------------------------------------------------------------------
// dir_offset_subvol_transform_top
// Pipeline: item accept to result valid passes 1 front + 8 divide stages.
// Throughput: one item per cycle while the output is not stalled; each stage
// holds one item, the eight divide stages resolve eight quotient bits each.
// Reset: asynchronous active low; clears valid bits, count resets to 1.
// ----------------------------------------------------------------------------
`include "dir_offset_subvol_transform_top_assert.svh"

module dir_offset_subvol_transform_top import dost_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,        // subvol_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,     // offset_in[63:0], subvol_index[69:64]
  input  logic [0:0]  s_axis_tuser_i,     // action[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o      // offset_out[63:0], subvol_out[69:64],
                                          // index_error[70]
);

  logic [CNT_W-1:0] count_q;
  logic             vld [DIV_STAGES+1];
  logic             rdy [DIV_STAGES+1];
  dost_item_t       stg [DIV_STAGES+1];
  dost_item_t       last;

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 7'd1;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  dost_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .action_i (s_axis_tuser_i[0]),
    .off_i    (s_axis_tdata_i[63:0]),
    .idx_i    (s_axis_tdata_i[69:64]),
    .count_i  (count_q),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .item_o   (stg[0])
  );

  // divide pipeline
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dost_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .item_i  (stg[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .item_o  (stg[k+1])
    );
  end

  assign rdy[DIV_STAGES] = m_axis_tready_i;
  assign last            = stg[DIV_STAGES];

  // result select
  assign m_axis_tvalid_o = vld[DIV_STAGES];
  assign m_axis_tdata_o  = {1'b0, last.err,
                            last.dec_div ? last.rem[IDX_W-1:0] : last.sub,
                            last.dec_div ? last.q : last.res};

  `DOST_ASSERT_IMPL(a_rem_below_cnt, clk_i, rst_ni, m_axis_tvalid_o && last.dec_div,
                    last.rem < last.cnt, "remainder not below count")
  `DOST_ASSERT_IMPL(a_div_no_err, clk_i, rst_ni, m_axis_tvalid_o && last.dec_div,
                    !last.err, "division path flagged an index error")
  `DOST_ASSERT_IMPL(a_err_sub_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[70],
                    m_axis_tdata_o[69:64] == '0, "index error with nonzero index")
  `DOST_ASSERT_NEXT(a_cnt_nonzero, clk_i, rst_ni, vld[0],
                    stg[0].cnt != '0, "effective count is zero")

endmodule

// ===== test/dir_offset_subvol_transform_top_tb.sv =====
// ----------------------------------------------------------------------------
// dir_offset_subvol_transform_top_tb
// Drives encode and decode items through the offset transform under several
// member counts, with random gaps on both streams, and checks every result.
// ----------------------------------------------------------------------------
module dir_offset_subvol_transform_top_tb;
  import dost_pkg::*;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef struct {
    logic             act;
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct {
    logic [OFF_W-1:0] off;
    logic [IDX_W-1:0] sub;
    logic             err;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;

  req_t        pending_q[$];
  rsp_t        expected_q[$];
  logic [6:0]  count_reg = 7'd1;
  int          mismatches = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          stim_done = 1'b0;

  dir_offset_subvol_transform_top dut (.*);

  always #1 clk_i = ~clk_i;

  // packed-offset transform for one item
  function automatic rsp_t transform(req_t r, logic [6:0] creg);
    rsp_t             o;
    logic [6:0]       c;
    int               b;
    logic [OFF_W-1:0] lowm, him, s;
    c = creg;
    if (c == 0) c = 1;
    if (c > MAX_SUBVOLS) c = MAX_SUBVOLS;
    b = 0;
    while ((1 << b) < c) b++;
    lowm = ALL_ONES << b;
    o.off = '0; o.sub = '0; o.err = 1'b0;
    if (r.act == ACT_ENCODE) begin
      o.err = (r.idx >= c);
      if (o.err) o.off = ALL_ONES;
      else if (r.off == ALL_ONES || c == 1) o.off = r.off;
      else begin
        him = ~(OFF_LOW63_MASK >> (b + 1));
        if ((r.off & him) != 0) o.off = TOP_BIT | ((r.off >> 1) & lowm) | r.idx;
        else o.off = r.off * c + r.idx;
      end
    end else begin
      if (c == 1) begin
        o.off = r.off; s = '0;
      end else if (r.off & TOP_BIT) begin
        o.off = ((r.off & ~TOP_BIT) & lowm) << 1;
        s = r.off & ~lowm;
      end else begin
        s = r.off % c;
        o.off = r.off / c;
      end
      if (s >= c) begin
        o.err = 1'b1; s = '0;
      end
      o.sub = s[IDX_W-1:0];
    end
    return o;
  endfunction

  // driver: one item per handshake, random gaps between items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(transform('{s_axis_tuser_i[0], s_axis_tdata_i[63:0],
                                         s_axis_tdata_i[69:64]}, count_reg));
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req_t r;
          r = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {2'b00, r.idx, r.off};
          s_axis_tuser_i <= r.act;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata_o);
        end else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (m_axis_tdata_o[63:0] !== e.off || m_axis_tdata_o[69:64] !== e.sub ||
              m_axis_tdata_o[70] !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp off=%h sub=%0d err=%b got off=%h sub=%0d err=%b",
                       e.off, e.sub, e.err, m_axis_tdata_o[63:0],
                       m_axis_tdata_o[69:64], m_axis_tdata_o[70]);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_gap = $urandom_range(0, 13);
      end
    end
  end

  // random offset biased toward the interesting regions
  function automatic logic [OFF_W-1:0] rand_off();
    logic [OFF_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = v | TOP_BIT;
      2: v = v & ~TOP_BIT;
      3: v = ALL_ONES;
      default: ;
    endcase
    return v;
  endfunction

  // wait for the pipe to drain, then write the member count
  task automatic set_count(logic [6:0] v);
    while (pending_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = v;
  endtask

  task automatic add(logic a, logic [OFF_W-1:0] o, logic [IDX_W-1:0] i);
    pending_q.push_back('{a, o, i});
  endtask

  initial begin
    logic [6:0] counts[10];
    counts = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd3, 7'd5, 7'd17, 7'd33, 7'd63};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset count, then edges at a few counts
    foreach (counts[k]) begin
      if (k > 0) set_count(counts[k]);
      if (k < 4 || k == 6) begin
        add(ACT_ENCODE, ALL_ONES, 0);
        add(ACT_ENCODE, ALL_ONES, 6'h3f);
        add(ACT_ENCODE, '0, 0);
        add(ACT_ENCODE, 64'h1234, 6'h3f);
        add(ACT_ENCODE, 64'h0000_FFFF_FFFF_FFFF, 1);
        add(ACT_ENCODE, 64'h8000_0000_0000_0001, 0);
        add(ACT_DECODE, TOP_BIT | 64'h3f, 0);
        add(ACT_DECODE, 64'h3FFF_FFFF_FFFF_FFFF, 0);
        add(ACT_DECODE, ALL_ONES, 0);
        add(ACT_DECODE, '0, 0);
      end
      // random part for this count
      repeat (150) add($urandom_range(0, 1), rand_off(), $urandom_range(0, 63));
    end
    while (pending_q.size() > 0 || s_axis_tvalid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
